// ===== sv/vibrational_field_map_top_assert.svh =====
// Assertion macros for the vibrational field map block.
`ifndef VIBRATIONAL_FIELD_MAP_TOP_ASSERT_SVH
`define VIBRATIONAL_FIELD_MAP_TOP_ASSERT_SVH

// Clocked check, switched off while reset is low.
`define VFM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds through reset.
`define VFM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== sv/vfm_pkg.sv =====
`default_nettype none

package vfm_pkg;

    localparam int Q_W    = 48;
    localparam int FRAC_W = 24;
    localparam int BOND_W = 26;
    localparam int BOX_W  = 47;
    localparam int CHROM_W = 12;
    localparam int FRAME_W = 16;

    typedef logic signed [Q_W-1:0] q_t;

    localparam q_t Q_MAX            = 48'sh7FFF_FFFF_FFFF;
    localparam q_t Q_MIN            = 48'sh8000_0000_0000;
    localparam q_t Q_ONE            = 48'sd16777216;
    localparam q_t Q_NEG_ONE        = -48'sd16777216;
    localparam q_t Q_FOUR_POINT_SIX = 48'sd77175194;

    // switching radius, Q24.24
    localparam longint SWITCH_RADIUS = 64'sd67108864;

    // fixed-point multiplier latency and the derived pipeline figures
    localparam int QMUL_LAT = 4;
    localparam int SW_LAT   = 2 * QMUL_LAT + 5;
    localparam int PIPE_LAT = 6 * QMUL_LAT + 4;

    localparam int NUM_COEFS = 8;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQ_C0     = 3'd0,
        CFG_FREQ_C1     = 3'd1,
        CFG_FREQ_C2     = 3'd2,
        CFG_DIPOLE_C0   = 3'd3,
        CFG_DIPOLE_C1   = 3'd4,
        CFG_DIPOLE_C2   = 3'd5,
        CFG_COUPLING_C0 = 3'd6,
        CFG_COUPLING_C1 = 3'd7
    } cfg_idx_t;

    // exact sum, clamped to the Q24.24 range
    function automatic q_t sat_add(input q_t a, input q_t b);
        logic signed [Q_W:0] s;
        s = $signed({a[Q_W-1], a}) + $signed({b[Q_W-1], b});
        if (s[Q_W] != s[Q_W-1])
            return s[Q_W] ? Q_MIN : Q_MAX;
        return q_t'(s[Q_W-1:0]);
    endfunction

endpackage

`default_nettype wire

// ===== sv/vfm_qmul.sv =====
`default_nettype none

// Q24.24 multiply, round half away from zero, saturate. Four stages.
module vfm_qmul
    import vfm_pkg::*;
(
    input  logic clk,
    input  q_t   a,
    input  q_t   b,
    output q_t   p
);

    localparam int HALF_W = Q_W / 2;
    localparam int PROD_W = 2 * Q_W;
    localparam int QUO_W  = PROD_W - FRAC_W;
    localparam logic [PROD_W-1:0] ROUND_BIT = PROD_W'(1) << (FRAC_W - 1);

    logic [Q_W-1:0]    ua, ub;
    logic [Q_W-1:0]    ma_next, mb_next, ma_reg, mb_reg;
    logic              neg1_reg, neg2_reg, neg3_reg;
    logic [Q_W-1:0]    p00_next, p01_next, p10_next, p11_next;
    logic [Q_W-1:0]    p00_reg, p01_reg, p10_reg, p11_reg;
    logic [PROD_W-1:0] sum_next;
    logic [QUO_W-1:0]  quo;
    logic              ovf_next, ovf_reg;
    logic [Q_W-2:0]    mag_reg;
    logic [Q_W-1:0]    mag_ext;
    q_t                p_next, p_reg;

    // stage 1: sign and magnitude
    always_comb
    begin
        ua = a;
        ub = b;
        ma_next = ua[Q_W-1] ? (~ua + Q_W'(1)) : ua;
        mb_next = ub[Q_W-1] ? (~ub + Q_W'(1)) : ub;
    end

    // stage 2: four half-width partial products
    always_comb
    begin
        p00_next = Q_W'(ma_reg[HALF_W-1:0]) * Q_W'(mb_reg[HALF_W-1:0]);
        p01_next = Q_W'(ma_reg[HALF_W-1:0]) * Q_W'(mb_reg[Q_W-1:HALF_W]);
        p10_next = Q_W'(ma_reg[Q_W-1:HALF_W]) * Q_W'(mb_reg[HALF_W-1:0]);
        p11_next = Q_W'(ma_reg[Q_W-1:HALF_W]) * Q_W'(mb_reg[Q_W-1:HALF_W]);
    end

    // stage 3: combine, round, drop the fraction
    always_comb
    begin
        sum_next = PROD_W'(p00_reg)
                 + (PROD_W'(p01_reg) << HALF_W)
                 + (PROD_W'(p10_reg) << HALF_W)
                 + (PROD_W'(p11_reg) << Q_W)
                 + ROUND_BIT;
        quo      = sum_next[PROD_W-1:FRAC_W];
        ovf_next = |quo[QUO_W-1:Q_W-1];
    end

    // stage 4: clamp and restore sign
    always_comb
    begin
        mag_ext = {1'b0, mag_reg};
        if (ovf_reg)
            p_next = neg3_reg ? Q_MIN : Q_MAX;
        else
            p_next = neg3_reg ? q_t'(~mag_ext + Q_W'(1)) : q_t'(mag_ext);
    end

    always_ff @(posedge clk)
    begin
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        neg1_reg <= a[Q_W-1] ^ b[Q_W-1];
        p00_reg  <= p00_next;
        p01_reg  <= p01_next;
        p10_reg  <= p10_next;
        p11_reg  <= p11_next;
        neg2_reg <= neg1_reg;
        mag_reg  <= quo[Q_W-2:0];
        ovf_reg  <= ovf_next;
        neg3_reg <= neg2_reg;
        p_reg    <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ===== sv/vfm_switch.sv =====
`default_nettype none

// Cubic switching factor of the slab-centred, box-wrapped height.
module vfm_switch
    import vfm_pkg::*;
(
    input  logic             clk,
    input  q_t               height,
    input  q_t               centre,
    input  logic [BOX_W-1:0] box,
    output q_t               s
);

    localparam int Z_W   = Q_W + 1;
    localparam int ZW_W  = Q_W + 2;
    localparam int ZM_W  = $clog2(SWITCH_RADIUS + 1);
    localparam int NUM_W = ZM_W + FRAC_W + 1;
    localparam int TM_W  = FRAC_W + 1;
    localparam int V_W   = TM_W + 3;
    localparam int T_N   = 2 * QMUL_LAT + 1;
    localparam int FL_N  = 2 * QMUL_LAT + 2;
    localparam logic signed [ZW_W-1:0] R_POS = ZW_W'(SWITCH_RADIUS);
    localparam logic signed [ZW_W-1:0] R_NEG = -R_POS;
    localparam logic [NUM_W-1:0] R_HALF = NUM_W'(SWITCH_RADIUS / 2);
    localparam logic [NUM_W-1:0] R_DIV  = NUM_W'(SWITCH_RADIUS);

    logic signed [Z_W-1:0]  z_reg;
    logic [BOX_W-1:0]       box_reg;
    logic signed [ZW_W-1:0] z2, boxs, zw_next, zw_reg;
    logic [ZW_W-1:0]        zabs;
    logic [NUM_W-1:0]       num, quo;
    logic signed [TM_W:0]   t_next;
    logic signed [TM_W:0]   t_dly_reg [T_N];
    logic                   hi_dly_reg [FL_N];
    logic                   lo_dly_reg [FL_N];
    q_t                     t_sq_in, t_cb_in, t2, t3;
    logic signed [V_W-1:0]  t_v, v_next, v_reg;
    logic [V_W-1:0]         vabs, vhalf;
    logic [Q_W-1:0]         s_mag;
    q_t                     s_next, s_reg;

    // minimum image: a single full-box step
    always_comb
    begin
        z2   = ZW_W'(z_reg) <<< 1;
        boxs = $signed(ZW_W'(box_reg));
        if (z2 > boxs)
            zw_next = ZW_W'(z_reg) - boxs;
        else if (z2 < -boxs)
            zw_next = ZW_W'(z_reg) + boxs;
        else
            zw_next = ZW_W'(z_reg);
    end

    // t = z / R in Q24.24, rounded; only used when |z| <= R
    always_comb
    begin
        zabs   = zw_reg[ZW_W-1] ? (~zw_reg + ZW_W'(1)) : zw_reg;
        num    = (NUM_W'(zabs[ZM_W-1:0]) << FRAC_W) + R_HALF;
        quo    = num / R_DIV;
        t_next = zw_reg[ZW_W-1] ? -$signed({1'b0, quo[TM_W-1:0]})
                                :  $signed({1'b0, quo[TM_W-1:0]});
    end

    assign t_sq_in = Q_W'(t_dly_reg[0]);
    assign t_cb_in = Q_W'(t_dly_reg[QMUL_LAT]);

    vfm_qmul u_square (.clk(clk), .a(t_sq_in), .b(t_sq_in), .p(t2));
    vfm_qmul u_cube   (.clk(clk), .a(t2),      .b(t_cb_in), .p(t3));

    // (3t - t^3) / 2, rounded half away from zero; +1 above R, -1 below -R
    always_comb
    begin
        t_v    = V_W'(t_dly_reg[2 * QMUL_LAT]);
        v_next = (t_v <<< 1) + t_v - $signed(t3[V_W-1:0]);
        vabs   = v_reg[V_W-1] ? (~v_reg + V_W'(1)) : v_reg;
        vhalf  = (vabs + V_W'(1)) >> 1;
        s_mag  = Q_W'(vhalf);
        if (hi_dly_reg[FL_N-1])
            s_next = Q_ONE;
        else if (lo_dly_reg[FL_N-1])
            s_next = Q_NEG_ONE;
        else
            s_next = v_reg[V_W-1] ? q_t'(~s_mag + Q_W'(1)) : q_t'(s_mag);
    end

    always_ff @(posedge clk)
    begin
        z_reg   <= $signed({height[Q_W-1], height}) - $signed({centre[Q_W-1], centre});
        box_reg <= box;
        zw_reg  <= zw_next;
        t_dly_reg[0]  <= t_next;
        hi_dly_reg[0] <= zw_reg > R_POS;
        lo_dly_reg[0] <= zw_reg < R_NEG;
        for (int i = 1; i < T_N; i++)
            t_dly_reg[i] <= t_dly_reg[i-1];
        for (int i = 1; i < FL_N; i++)
        begin
            hi_dly_reg[i] <= hi_dly_reg[i-1];
            lo_dly_reg[i] <= lo_dly_reg[i-1];
        end
        v_reg <= v_next;
        s_reg <= s_next;
    end

    assign s = s_reg;

endmodule

`default_nettype wire

// ===== sv/vibrational_field_map_top.sv =====
`default_nettype none

// Vibrational field map: one chromophore per item, fully pipelined.
// Input: raise start with the item fields for one cycle; the transfer
// happens at that edge when busy is low. busy stays low, so a new item may
// be given every cycle.
// Output: done pulses for exactly one cycle with the result fields; done_reg
// is fed from the end of the valid line that the transfer enters. Results
// leave in input order at up to one per cycle; the receiver cannot stall and
// nothing inside ever waits, so there is no back-pressure path.
// Latency is set by the longest dependent chain of Q24.24 multiplies:
// field -> coef*F -> *F -> frequency -> coupling -> *m -> *bond_z -> *switch,
// six multiplies of QMUL_LAT stages each plus saturating add stages.
// Each 48x48 multiply is split into four 24x24 partial products.
// Config: cfg_valid/cfg_ready/cfg_index/cfg_data write one coefficient per
// transfer; cfg_ready is always high. Write only while no item is in flight.
// Reset (rst_n low, asynchronous) clears all coefficients to zero and drops
// every in-flight item; the data path itself is not reset.
module vibrational_field_map_top
    import vfm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  q_t                     cfg_data,
    input  logic                   start,
    output logic                   busy,
    input  logic [CHROM_W-1:0]     chromophore_index,
    input  logic [FRAME_W-1:0]     frame_index,
    input  q_t                     field_projection,
    input  logic signed [BOND_W-1:0] bond_dir_x,
    input  logic signed [BOND_W-1:0] bond_dir_y,
    input  logic signed [BOND_W-1:0] bond_dir_z,
    input  q_t                     dipole_height,
    input  q_t                     slab_center_z,
    input  logic [BOX_W-1:0]       box_length_z,
    output logic                   done,
    output logic [CHROM_W-1:0]     chromophore_tag,
    output logic [FRAME_W-1:0]     frame_tag,
    output q_t                     frequency,
    output q_t                     dipole_z,
    output q_t                     polarizability
);

    // Delay line lengths; each line is read at its last element.
    localparam int A_N = QMUL_LAT;                    // F, bx, by to level 2
    localparam int B_N = QMUL_LAT;                    // linear terms to the first adds
    localparam int C_N = QMUL_LAT + 1;                // m, px, py to coupling
    localparam int D_N = 4 * QMUL_LAT + 3;            // bond z to second dipole mult
    localparam int E_N = 5 * QMUL_LAT + 3 - SW_LAT;   // switch factor to last mult
    localparam int F_N = 2 * QMUL_LAT - 1;            // polarizability to output
    localparam int G_N = 4 * QMUL_LAT + 1;            // frequency to output
    localparam int H_N = PIPE_LAT - 1;                // tags and valid to output

    q_t coef_reg [NUM_COEFS];

    logic in_take;

    // delay lines
    q_t                      f_a_reg   [A_N];
    logic signed [BOND_W-1:0] bx_a_reg [A_N];
    logic signed [BOND_W-1:0] by_a_reg [A_N];
    q_t                      p1_b_reg  [B_N];
    q_t                      d1_b_reg  [B_N];
    logic                    fpos_b_reg [B_N];
    q_t                      m_c_reg   [C_N];
    q_t                      px_c_reg  [C_N];
    q_t                      py_c_reg  [C_N];
    logic signed [BOND_W-1:0] bz_d_reg [D_N];
    q_t                      s_e_reg   [E_N];
    q_t                      alpha_f_reg [F_N];
    q_t                      w_g_reg   [G_N];
    logic [CHROM_W-1:0]      chrom_h_reg [H_N];
    logic [FRAME_W-1:0]      frame_h_reg [H_N];
    logic                    vld_h_reg [H_N];

    // multiplier results
    q_t p1, p2, d1, d2, x1, y1;
    q_t p3, d3, x2, y2;
    q_t c1, m1, a1, a2, m2, m3;
    q_t sw;

    // sum stages
    q_t wa_reg, ma_reg, p3_reg, d3_reg, px_reg, py_reg;
    q_t wsum_reg, msum_reg, px2_reg, py2_reg;
    q_t c_reg, alpha_reg;

    // output registers
    logic               done_reg;
    logic [CHROM_W-1:0] chrom_out_reg;
    logic [FRAME_W-1:0] frame_out_reg;
    q_t                 freq_out_reg, dip_out_reg, pol_out_reg;

    // The pipeline never waits, so items are always taken.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_take   = start && !busy;

    // Level 1: everything that depends on the inputs alone.
    vfm_qmul u_f1 (.clk(clk), .a(coef_reg[CFG_FREQ_C1]),   .b(field_projection), .p(p1));
    vfm_qmul u_f2 (.clk(clk), .a(coef_reg[CFG_FREQ_C2]),   .b(field_projection), .p(p2));
    vfm_qmul u_d1 (.clk(clk), .a(coef_reg[CFG_DIPOLE_C1]), .b(field_projection), .p(d1));
    vfm_qmul u_d2 (.clk(clk), .a(coef_reg[CFG_DIPOLE_C2]), .b(field_projection), .p(d2));
    vfm_qmul u_x1 (.clk(clk), .a(Q_FOUR_POINT_SIX), .b(Q_W'(bond_dir_x)), .p(x1));
    vfm_qmul u_y1 (.clk(clk), .a(Q_FOUR_POINT_SIX), .b(Q_W'(bond_dir_y)), .p(y1));

    // Switching factor runs alongside; ready long before the last multiply.
    vfm_switch u_switch (
        .clk    (clk),
        .height (dipole_height),
        .centre (slab_center_z),
        .box    (box_length_z),
        .s      (sw)
    );

    // Level 2: second field factor of the quadratic terms, squared bond terms.
    vfm_qmul u_f3 (.clk(clk), .a(p2), .b(f_a_reg[A_N-1]), .p(p3));
    vfm_qmul u_d3 (.clk(clk), .a(d2), .b(f_a_reg[A_N-1]), .p(d3));
    vfm_qmul u_x2 (.clk(clk), .a(x1), .b(Q_W'(bx_a_reg[A_N-1])), .p(x2));
    vfm_qmul u_y2 (.clk(clk), .a(y1), .b(Q_W'(by_a_reg[A_N-1])), .p(y2));

    // Level 3: coupling slope times frequency.
    vfm_qmul u_c1 (.clk(clk), .a(coef_reg[CFG_COUPLING_C1]), .b(wsum_reg), .p(c1));

    // Level 4: coupling times dipole derivative and in-plane terms.
    vfm_qmul u_m1 (.clk(clk), .a(m_c_reg[C_N-1]), .b(c_reg), .p(m1));
    vfm_qmul u_a1 (.clk(clk), .a(c_reg), .b(px_c_reg[C_N-1]), .p(a1));
    vfm_qmul u_a2 (.clk(clk), .a(c_reg), .b(py_c_reg[C_N-1]), .p(a2));

    // Levels 5 and 6: bond z, then switching factor.
    vfm_qmul u_m2 (.clk(clk), .a(m1), .b(Q_W'(bz_d_reg[D_N-1])), .p(m2));
    vfm_qmul u_m3 (.clk(clk), .a(m2), .b(s_e_reg[E_N-1]),        .p(m3));

    // Control: coefficients, valid line, result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFS; i++)
                coef_reg[i] <= '0;
            for (int i = 0; i < H_N; i++)
                vld_h_reg[i] <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                coef_reg[cfg_index] <= cfg_data;
            vld_h_reg[0] <= in_take;
            for (int i = 1; i < H_N; i++)
                vld_h_reg[i] <= vld_h_reg[i-1];
            done_reg <= vld_h_reg[H_N-1];
        end
    end

    // Data path: free-running, every stage advances each cycle.
    always_ff @(posedge clk)
    begin
        f_a_reg[0]  <= field_projection;
        bx_a_reg[0] <= bond_dir_x;
        by_a_reg[0] <= bond_dir_y;
        for (int i = 1; i < A_N; i++)
        begin
            f_a_reg[i]  <= f_a_reg[i-1];
            bx_a_reg[i] <= bx_a_reg[i-1];
            by_a_reg[i] <= by_a_reg[i-1];
        end

        p1_b_reg[0]   <= p1;
        d1_b_reg[0]   <= d1;
        fpos_b_reg[0] <= !f_a_reg[A_N-1][Q_W-1];
        for (int i = 1; i < B_N; i++)
        begin
            p1_b_reg[i]   <= p1_b_reg[i-1];
            d1_b_reg[i]   <= d1_b_reg[i-1];
            fpos_b_reg[i] <= fpos_b_reg[i-1];
        end

        // first adds; the quadratic term only counts for a non-negative field
        wa_reg <= sat_add(coef_reg[CFG_FREQ_C0], p1_b_reg[B_N-1]);
        ma_reg <= sat_add(coef_reg[CFG_DIPOLE_C0], d1_b_reg[B_N-1]);
        p3_reg <= fpos_b_reg[B_N-1] ? p3 : '0;
        d3_reg <= fpos_b_reg[B_N-1] ? d3 : '0;
        px_reg <= sat_add(x2, Q_ONE);
        py_reg <= sat_add(y2, Q_ONE);

        wsum_reg <= sat_add(wa_reg, p3_reg);
        msum_reg <= sat_add(ma_reg, d3_reg);
        px2_reg  <= px_reg;
        py2_reg  <= py_reg;

        m_c_reg[0]  <= msum_reg;
        px_c_reg[0] <= px2_reg;
        py_c_reg[0] <= py2_reg;
        for (int i = 1; i < C_N; i++)
        begin
            m_c_reg[i]  <= m_c_reg[i-1];
            px_c_reg[i] <= px_c_reg[i-1];
            py_c_reg[i] <= py_c_reg[i-1];
        end

        c_reg     <= sat_add(coef_reg[CFG_COUPLING_C0], c1);
        alpha_reg <= sat_add(a1, a2);

        bz_d_reg[0] <= bond_dir_z;
        for (int i = 1; i < D_N; i++)
            bz_d_reg[i] <= bz_d_reg[i-1];

        s_e_reg[0] <= sw;
        for (int i = 1; i < E_N; i++)
            s_e_reg[i] <= s_e_reg[i-1];

        alpha_f_reg[0] <= alpha_reg;
        for (int i = 1; i < F_N; i++)
            alpha_f_reg[i] <= alpha_f_reg[i-1];

        w_g_reg[0] <= wsum_reg;
        for (int i = 1; i < G_N; i++)
            w_g_reg[i] <= w_g_reg[i-1];

        chrom_h_reg[0] <= chromophore_index;
        frame_h_reg[0] <= frame_index;
        for (int i = 1; i < H_N; i++)
        begin
            chrom_h_reg[i] <= chrom_h_reg[i-1];
            frame_h_reg[i] <= frame_h_reg[i-1];
        end

        chrom_out_reg <= chrom_h_reg[H_N-1];
        frame_out_reg <= frame_h_reg[H_N-1];
        freq_out_reg  <= w_g_reg[G_N-1];
        dip_out_reg   <= m3;
        pol_out_reg   <= alpha_f_reg[F_N-1];
    end

    assign done            = done_reg;
    assign chromophore_tag = chrom_out_reg;
    assign frame_tag       = frame_out_reg;
    assign frequency       = freq_out_reg;
    assign dipole_z        = dip_out_reg;
    assign polarizability  = pol_out_reg;

endmodule

`default_nettype wire

// ===== sv/vfm_checker.sv =====
`default_nettype none

`include "vibrational_field_map_top_assert.svh"

module vfm_checker
    import vfm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [CHROM_W-1:0] chromophore_index,
    input logic [FRAME_W-1:0] frame_index,
    input logic [CHROM_W-1:0] chromophore_tag,
    input logic [FRAME_W-1:0] frame_tag
);

    // every strobe traces back to a transfer a fixed latency earlier
    `VFM_ASSERT(a_done_has_start, done |-> $past(start && !busy, PIPE_LAT), "strobe without transfer")

    // tags must stay aligned with the arithmetic through the whole pipe
    `VFM_ASSERT(a_chrom_tag, done |-> chromophore_tag == $past(chromophore_index, PIPE_LAT), "chromophore tag misaligned")
    `VFM_ASSERT(a_frame_tag, done |-> frame_tag == $past(frame_index, PIPE_LAT), "frame tag misaligned")

    // coefficient writes are never held off
    `VFM_ASSERT_ALWAYS(a_cfg_taken, cfg_valid |-> cfg_ready, "config write held off")

endmodule

bind vibrational_field_map_top vfm_checker u_vfm_checker (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vfm_pkg::*;

    // ---------------------------------------------------------------------
    // Types and constants
    // ---------------------------------------------------------------------
    typedef logic signed [BOND_W-1:0] bond_t;

    // one chromophore as presented on the input ports
    typedef struct {
        logic [CHROM_W-1:0] chrom;
        logic [FRAME_W-1:0] frame;
        q_t                 field;
        bond_t              bx;
        bond_t              by;
        bond_t              bz;
        q_t                 height;
        q_t                 center;
        logic [BOX_W-1:0]   box;
    } chrom_item_t;

    // the mapped spectroscopic values for one chromophore
    typedef struct {
        logic [CHROM_W-1:0] chrom;
        logic [FRAME_W-1:0] frame;
        q_t                 freq;
        q_t                 dipole;
        q_t                 polar;
    } spectro_values_t;

    typedef q_t coef_set_t [NUM_COEFS];

    // styles of coefficient sets loaded between phases
    typedef enum {
        SET_TYPICAL,
        SET_WIDE,
        SET_MAX,
        SET_MIN,
        SET_ZERO,
        SET_ALTERNATE
    } coef_style_t;

    localparam longint UNIT        = 64'sd1 << FRAC_W;
    localparam longint RADIUS      = SWITCH_RADIUS;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     ITEMS_PER_PHASE = 230;

    // magnitude (as a bit count) of each coefficient in a physically sane set
    localparam int TYPICAL_BITS [NUM_COEFS] = '{36, 28, 24, 30, 26, 22, 26, 22};

    localparam coef_style_t STYLE_ORDER [8] = '{
        SET_TYPICAL, SET_WIDE, SET_MAX, SET_TYPICAL,
        SET_MIN, SET_ZERO, SET_ALTERNATE, SET_TYPICAL
    };

    // ---------------------------------------------------------------------
    // Clock, reset and DUT signals (all inputs known from time zero)
    // ---------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    cfg_idx_t           cfg_index = CFG_FREQ_C0;
    q_t                 cfg_data  = '0;

    logic               start = 1'b0;
    logic               busy;
    logic [CHROM_W-1:0] chromophore_index = '0;
    logic [FRAME_W-1:0] frame_index       = '0;
    q_t                 field_projection  = '0;
    bond_t              bond_dir_x        = '0;
    bond_t              bond_dir_y        = '0;
    bond_t              bond_dir_z        = '0;
    q_t                 dipole_height     = '0;
    q_t                 slab_center_z     = '0;
    logic [BOX_W-1:0]   box_length_z      = '0;

    logic               done;
    logic [CHROM_W-1:0] chromophore_tag;
    logic [FRAME_W-1:0] frame_tag;
    q_t                 frequency;
    q_t                 dipole_z;
    q_t                 polarizability;

    always #5 clk = ~clk;

    vibrational_field_map_top u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .start             (start),
        .busy              (busy),
        .chromophore_index (chromophore_index),
        .frame_index       (frame_index),
        .field_projection  (field_projection),
        .bond_dir_x        (bond_dir_x),
        .bond_dir_y        (bond_dir_y),
        .bond_dir_z        (bond_dir_z),
        .dipole_height     (dipole_height),
        .slab_center_z     (slab_center_z),
        .box_length_z      (box_length_z),
        .done              (done),
        .chromophore_tag   (chromophore_tag),
        .frame_tag         (frame_tag),
        .frequency         (frequency),
        .dipole_z          (dipole_z),
        .polarizability    (polarizability)
    );

    // ---------------------------------------------------------------------
    // Testbench state
    // ---------------------------------------------------------------------
    q_t              coef [NUM_COEFS];       // our copy of the coefficient registers
    chrom_item_t     pending_items[$];       // filled by the sequence, drained by driver
    spectro_values_t expected_values[$];     // one entry per accepted chromophore
    int              n_queued    = 0;
    int              n_accepted  = 0;
    int              n_results   = 0;
    int              n_mismatch  = 0;
    int              n_settings  = 0;
    int              cycle_count = 0;
    bit              no_gaps     = 1'b0;     // phase-wide back-to-back mode

    // driver bookkeeping
    chrom_item_t     on_port;                // item currently shown with start high
    chrom_item_t     staged_item;            // next item, waiting out its gap
    bit              staged   = 1'b0;
    int              gap_left = 0;

    initial foreach (coef[i]) coef[i] = '0;

    // ---------------------------------------------------------------------
    // Q24.24 arithmetic, written from the spec of the map
    // ---------------------------------------------------------------------
    function automatic q_t to_q(longint v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return q_t'(v);
    endfunction

    function automatic q_t q_add(q_t a, q_t b);
        return to_q(longint'(a) + longint'(b));
    endfunction

    // exact product, rounded on the magnitude (ties away from zero), clamped
    function automatic q_t q_mul(q_t a, q_t b);
        longint       la, lb;
        logic [127:0] prod;
        logic         neg;
        la   = a;
        lb   = b;
        neg  = (la < 0) != (lb < 0);
        la   = (la < 0) ? -la : la;
        lb   = (lb < 0) ? -lb : lb;
        prod = {64'd0, la} * {64'd0, lb};
        prod = (prod + (128'd1 << (FRAC_W - 1))) >> FRAC_W;
        if (prod >= (128'd1 << (Q_W - 1)))
            return neg ? Q_MIN : Q_MAX;
        la = longint'(prod[Q_W-1:0]);
        return q_t'(neg ? -la : la);
    endfunction

    // cubic switch on the slab-centred height after one minimum-image step
    function automatic q_t switch_factor(q_t height, q_t center, logic [BOX_W-1:0] box);
        longint z, l, t, mz, v, vm;
        q_t     tq, t3;
        l = longint'(box);
        z = longint'(height) - longint'(center);
        if (2 * z > l)
            z = z - l;
        else if (2 * z < -l)
            z = z + l;
        if (z > RADIUS)
            return Q_ONE;
        if (z < -RADIUS)
            return Q_NEG_ONE;
        mz = (z < 0) ? -z : z;
        t  = ((mz << FRAC_W) + (RADIUS >>> 1)) / RADIUS;
        if (z < 0)
            t = -t;
        tq = q_t'(t);
        t3 = q_mul(q_mul(tq, tq), tq);
        v  = 3 * t - longint'(t3);
        vm = (((v < 0) ? -v : v) + 1) >>> 1;
        return to_q((v < 0) ? -vm : vm);
    endfunction

    // frequency, switched dipole and polarizability of one chromophore
    function automatic spectro_values_t map_chromophore(chrom_item_t it);
        spectro_values_t r;
        q_t              f, w, m, c, bx, by, bz, px, py;
        f  = it.field;
        bx = it.bx;
        by = it.by;
        bz = it.bz;
        w  = q_add(coef[CFG_FREQ_C0], q_mul(coef[CFG_FREQ_C1], f));
        m  = q_add(coef[CFG_DIPOLE_C0], q_mul(coef[CFG_DIPOLE_C1], f));
        // quadratic term only on the non-negative side of the field
        if (f >= 0) begin
            w = q_add(w, q_mul(q_mul(coef[CFG_FREQ_C2], f), f));
            m = q_add(m, q_mul(q_mul(coef[CFG_DIPOLE_C2], f), f));
        end
        c  = q_add(coef[CFG_COUPLING_C0], q_mul(coef[CFG_COUPLING_C1], w));
        px = q_add(q_mul(q_mul(Q_FOUR_POINT_SIX, bx), bx), Q_ONE);
        py = q_add(q_mul(q_mul(Q_FOUR_POINT_SIX, by), by), Q_ONE);
        r.chrom  = it.chrom;
        r.frame  = it.frame;
        r.freq   = w;
        r.dipole = q_mul(q_mul(q_mul(m, c), bz),
                         switch_factor(it.height, it.center, it.box));
        r.polar  = q_add(q_mul(c, px), q_mul(c, py));
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Random stimulus helpers
    // ---------------------------------------------------------------------
    // signed value in [-2^bits, 2^bits)
    function automatic longint rand_span(int bits);
        longint v;
        v = {$urandom(), $urandom()};
        return v >>> (63 - bits);
    endfunction

    function automatic coef_set_t coef_setting(coef_style_t style);
        coef_set_t v;
        foreach (v[i]) begin
            case (style)
                SET_ZERO:      v[i] = '0;
                SET_MAX:       v[i] = Q_MAX;
                SET_MIN:       v[i] = Q_MIN;
                SET_ALTERNATE: v[i] = i[0] ? Q_MIN : Q_MAX;
                SET_WIDE:      v[i] = q_t'(rand_span(Q_W - 1));
                default:       v[i] = q_t'(rand_span(TYPICAL_BITS[i]));
            endcase
        end
        return v;
    endfunction

    function automatic bond_t rand_bond();
        // mostly within the unit range, sometimes anywhere in 26 bits
        if ($urandom_range(0, 7) == 0)
            return bond_t'(rand_span(BOND_W - 1));
        return bond_t'(int'($urandom_range(0, 32'h0200_0000)) - int'(UNIT));
    endfunction

    function automatic chrom_item_t random_item();
        chrom_item_t it;
        longint      l, off;
        it.chrom = CHROM_W'($urandom());
        it.frame = FRAME_W'($urandom());
        case ($urandom_range(0, 9))
            0, 1:    it.field = q_t'(rand_span(Q_W - 1));
            7:       it.field = q_t'(rand_span(40));
            8: begin
                case ($urandom_range(0, 4))
                    0:       it.field = Q_MAX;
                    1:       it.field = Q_MIN;
                    2:       it.field = '0;
                    3:       it.field = q_t'(1);
                    default: it.field = q_t'(-1);
                endcase
            end
            9:       it.field = q_t'(rand_span(32));
            default: it.field = q_t'(rand_span(27));
        endcase
        it.bx = rand_bond();
        it.by = rand_bond();
        it.bz = rand_bond();
        case ($urandom_range(0, 9))
            6:       l = 0;
            7:       l = rand_span(BOX_W) & ((64'sd1 << BOX_W) - 1);
            8:       l = (64'sd1 << BOX_W) - 1;
            9:       l = longint'($urandom_range(0, 32'h0400_0000));
            default: l = longint'($urandom_range(32'h0400_0000, 32'hFFFF_FFFF));
        endcase
        it.box    = BOX_W'(l);
        it.center = ($urandom_range(0, 9) < 7) ? q_t'(rand_span(40))
                                               : q_t'(rand_span(Q_W - 1));
        case ($urandom_range(0, 9))
            // one box away: wraps back into the switching region
            6:       off = ($urandom_range(0, 1) ? l : -l) + rand_span(26);
            // half a box away: straddles the wrap threshold
            7:       off = ($urandom_range(0, 1) ? (l >>> 1) : -(l >>> 1)) + rand_span(26);
            8:       off = rand_span(Q_W - 1) - longint'(it.center);
            9:       off = rand_span(40);
            default: off = rand_span(27);
        endcase
        it.height = to_q(longint'(it.center) + off);
        return it;
    endfunction

    function automatic int draw_gap();
        if (no_gaps || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // ---------------------------------------------------------------------
    // Mismatch reporting
    // ---------------------------------------------------------------------
    task automatic flag_mismatch(string what, longint got, longint want);
        n_mismatch++;
        if (n_mismatch <= 200)
            $display("ERROR t=%0t result %0d %s: got %0d, want %0d",
                     $time, n_results, what, got, want);
    endtask

    // ---------------------------------------------------------------------
    // Driver: takes items from pending_items, waits the drawn gap, then holds
    // start high until the transfer. On the transfer edge the expectation is
    // computed from the item that was on the ports and the current coefficient
    // copy. start is assigned once per edge, so back-to-back items keep it high.
    // ---------------------------------------------------------------------
    always @(posedge clk) begin
        logic raise;
        if (!rst_n) begin
            start <= 1'b0;
        end else begin
            raise = start;
            if (start && !busy) begin
                expected_values.push_back(map_chromophore(on_port));
                n_accepted++;
                raise = 1'b0;
            end
            if (!raise) begin
                if (!staged && pending_items.size() > 0) begin
                    staged_item = pending_items.pop_front();
                    staged      = 1'b1;
                    gap_left    = draw_gap();
                end
                if (staged) begin
                    if (gap_left == 0) begin
                        on_port           = staged_item;
                        staged            = 1'b0;
                        raise             = 1'b1;
                        chromophore_index <= staged_item.chrom;
                        frame_index       <= staged_item.frame;
                        field_projection  <= staged_item.field;
                        bond_dir_x        <= staged_item.bx;
                        bond_dir_y        <= staged_item.by;
                        bond_dir_z        <= staged_item.bz;
                        dipole_height     <= staged_item.height;
                        slab_center_z     <= staged_item.center;
                        box_length_z      <= staged_item.box;
                    end else begin
                        gap_left--;
                    end
                end
            end
            start <= raise;
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: every done pulse is one result transfer; compare in order.
    // ---------------------------------------------------------------------
    always @(posedge clk) begin
        spectro_values_t want;
        if (rst_n && done) begin
            n_results++;
            if (expected_values.size() == 0) begin
                flag_mismatch("result with nothing outstanding, frequency", frequency, 0);
            end else begin
                want = expected_values.pop_front();
                if (chromophore_tag !== want.chrom)
                    flag_mismatch("chromophore_tag", chromophore_tag, want.chrom);
                if (frame_tag !== want.frame)
                    flag_mismatch("frame_tag", frame_tag, want.frame);
                if (frequency !== want.freq)
                    flag_mismatch("frequency", frequency, want.freq);
                if (dipole_z !== want.dipole)
                    flag_mismatch("dipole_z", dipole_z, want.dipole);
                if (polarizability !== want.polar)
                    flag_mismatch("polarizability", polarizability, want.polar);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog
    // ---------------------------------------------------------------------
    always @(posedge clk) cycle_count++;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Sequence helpers (called on a clock edge)
    // ---------------------------------------------------------------------
    task automatic queue_item(chrom_item_t it);
        pending_items.push_back(it);
        n_queued++;
    endtask

    task automatic push_directed(int chrom, int frame, longint f, longint bx, longint by,
                                 longint bz, longint h, longint c, longint box);
        chrom_item_t it;
        it.chrom  = CHROM_W'(chrom);
        it.frame  = FRAME_W'(frame);
        it.field  = to_q(f);
        it.bx     = bond_t'(bx);
        it.by     = bond_t'(by);
        it.bz     = bond_t'(bz);
        it.height = to_q(h);
        it.center = to_q(c);
        it.box    = BOX_W'(box);
        queue_item(it);
    endtask

    // wait until every queued item went through and every result came back
    task automatic drain();
        while (n_accepted != n_queued || expected_values.size() != 0 || staged)
            @(posedge clk);
    endtask

    // write all coefficients in one burst; valid stays high between writes
    task automatic load_coefs(coef_set_t vals);
        for (int i = 0; i < NUM_COEFS; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            coef[i] = vals[i];
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            queue_item(random_item());
        drain();
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coefficients straight out of reset (all zero)
        run_random(10);

        // directed corners under a sane coefficient set
        load_coefs(coef_setting(SET_TYPICAL));
        // all zero
        push_directed(0, 0, 0, 0, 0, 0, 0, 0, 0);
        // field and tags at their top, height difference far beyond the box
        push_directed(4095, 65535, longint'(Q_MAX), UNIT, UNIT, UNIT,
                      longint'(Q_MAX), longint'(Q_MIN), (64'sd1 << BOX_W) - 1);
        // field at its bottom, zero box, extreme negative height difference
        push_directed(1, 2, longint'(Q_MIN), -UNIT, -UNIT, -UNIT,
                      longint'(Q_MIN), longint'(Q_MAX), 0);
        // smallest positive / negative field; height at and just past the radius
        push_directed(3, 4, 1, 10066330, 8388608, 13421773,
                      7 * UNIT + RADIUS, 7 * UNIT, 100 * UNIT);
        push_directed(5, 6, -1, -8388608, 10066330, -13421773,
                      7 * UNIT + RADIUS + 1, 7 * UNIT, 100 * UNIT);
        push_directed(7, 8, 2 * UNIT, 0, UNIT, UNIT / 2,
                      -3 * UNIT - RADIUS, -3 * UNIT, 100 * UNIT);
        push_directed(9, 10, -2 * UNIT, UNIT, 0, -UNIT / 2,
                      -3 * UNIT - RADIUS - 1, -3 * UNIT, 100 * UNIT);
        // zero box with a nonzero height: the wrap moves by zero
        push_directed(11, 12, UNIT / 2, UNIT / 3, UNIT / 4, UNIT,
                      RADIUS / 2, 0, 0);
        push_directed(13, 14, -3 * UNIT, -UNIT / 3, UNIT / 5, -UNIT,
                      -RADIUS / 3, 0, 0);
        // minimum image both ways, then exactly on the half-box threshold
        push_directed(15, 16, UNIT, UNIT / 2, UNIT / 2, UNIT,
                      9 * UNIT, 0, 10 * UNIT);
        push_directed(17, 18, -UNIT, UNIT / 2, -UNIT / 2, UNIT,
                      -9 * UNIT, 0, 10 * UNIT);
        push_directed(19, 20, UNIT, UNIT, UNIT, UNIT, 5 * UNIT, 0, 10 * UNIT);
        push_directed(21, 22, UNIT, UNIT, UNIT, UNIT, -5 * UNIT, 0, 10 * UNIT);
        // bond components past unit length, full 26-bit extremes
        push_directed(23, 24, UNIT, (64'sd1 << 25) - 1, -(64'sd1 << 25),
                      (64'sd1 << 25) - 1, UNIT, 0, 100 * UNIT);
        push_directed(25, 26, -UNIT, -(64'sd1 << 25), (64'sd1 << 25) - 1,
                      -(64'sd1 << 25), -UNIT, 0, 100 * UNIT);
        // large fields drive the maps into saturation
        push_directed(27, 28, 64'sd1 << 40, UNIT, UNIT, UNIT, UNIT, 0, 100 * UNIT);
        push_directed(29, 30, -(64'sd1 << 40), UNIT, UNIT, UNIT, -UNIT, 0, 100 * UNIT);
        // one LSB either side of the slab centre
        push_directed(31, 32, 0, UNIT, UNIT, UNIT, 1, 0, 100 * UNIT);
        push_directed(33, 34, 0, UNIT, UNIT, UNIT, -1, 0, 100 * UNIT);
        push_directed(35, 36, 3 * UNIT, UNIT / 7, UNIT / 9, UNIT / 3,
                      2 * UNIT, 0, (64'sd1 << BOX_W) - 1);
        drain();

        // random phases, one coefficient set each; every third runs without gaps
        foreach (STYLE_ORDER[p]) begin
            load_coefs(coef_setting(STYLE_ORDER[p]));
            no_gaps = (p % 3 == 1);
            run_random(ITEMS_PER_PHASE);
        end

        // let any stray result show up
        repeat (PIPE_LAT + 10) @(posedge clk);

        $display("Run covered %0d chromophores over %0d coefficient sets (reset, sane, wide,",
                 n_accepted, n_settings + 1);
        $display("saturating and zero), %0d results checked, %0d field errors",
                 n_results, n_mismatch);
        if (n_mismatch == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
